/* rtl/cpi_pkg.sv */
package cpi_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd7;

  typedef struct packed {
    logic valid;
    logic sat;
  } div_stat_t;

endpackage

/* rtl/capsule_pair_intersect_top.sv */
// Capsule pair overlap test, fully pipelined: one candidate may start every cycle.
// The pipeline holds three chained restoring dividers of POS_WIDTH+1 quotient stages each.
// Throughput: one item per cycle; busy stays low and results cannot be held off.
// Reset (rst, synchronous): clears all valid bits and the reference registers to zero.
module capsule_pair_intersect_top #(
  parameter int POS_WIDTH     = 16,
  parameter int DIR_FRAC_BITS = 14
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   cfg_we,
  input  logic [cpi_pkg::CFG_IDX_W-1:0]          cfg_idx,
  input  logic [((POS_WIDTH > DIR_FRAC_BITS+2) ? POS_WIDTH : DIR_FRAC_BITS+2)-1:0] cfg_wdata,
  input  logic signed [POS_WIDTH-1:0]            cand_center_x,
  input  logic signed [POS_WIDTH-1:0]            cand_center_y,
  input  logic signed [POS_WIDTH-1:0]            cand_center_z,
  input  logic signed [DIR_FRAC_BITS+1:0]        cand_dir_x,
  input  logic signed [DIR_FRAC_BITS+1:0]        cand_dir_y,
  input  logic signed [DIR_FRAC_BITS+1:0]        cand_dir_z,
  input  logic [POS_WIDTH-1:0]                   cand_height,
  input  logic [POS_WIDTH-1:0]                   cand_radius,
  output logic                                   done,
  output logic                                   hit
);

  localparam int PW   = POS_WIDTH;
  localparam int DW   = DIR_FRAC_BITS + 2;
  localparam int K    = DIR_FRAC_BITS + 1;
  localparam int RW   = PW + 1;
  localparam int AW   = 2 * DIR_FRAC_BITS + 2;
  localparam int BW   = AW + 1;
  localparam int FW   = PW + DIR_FRAC_BITS + 3;
  localparam int TW   = PW + 1;
  localparam int NS1  = BW + FW + 1;
  localparam int N1W  = NS1 + K;
  localparam int DNW  = 2 * AW;
  localparam int N2S  = PW + 2 * DIR_FRAC_BITS + 5;
  localparam int WW   = PW + DIR_FRAC_BITS + 5;
  localparam int SW   = WW - 2;
  localparam int DSW  = 2 * SW + 2;
  localparam int THW  = 2 * PW + 2 * DIR_FRAC_BITS;
  localparam int CMPW = ((DSW > THW) ? DSW : THW) + 1;
  localparam logic signed [DW-1:0] DLIM = DW'(2 ** DIR_FRAC_BITS);

  typedef struct packed {
    logic signed [BW-1:0] b;
    logic signed [FW-1:0] d;
    logic signed [FW-1:0] f;
    logic [AW-1:0]        a;
    logic [AW-1:0]        c;
    logic [2:0][RW-1:0]   r;
    logic [2:0][DW-1:0]   qd;
    logic [PW-1:0]        qext;
    logic [PW-1:0]        qrad;
    logic                 a_nz;
    logic                 c_nz;
    logic                 use1;
  } sd1_t;

  typedef struct packed {
    logic signed [BW-1:0] b;
    logic signed [FW-1:0] d;
    logic [AW-1:0]        a;
    logic [2:0][RW-1:0]   r;
    logic [2:0][DW-1:0]   qd;
    logic [PW-1:0]        qrad;
    logic signed [TW-1:0] t1;
    logic                 a_nz;
    logic                 c_nz;
  } sd2_t;

  typedef struct packed {
    logic [2:0][RW-1:0]   r;
    logic [2:0][DW-1:0]   qd;
    logic [PW-1:0]        qrad;
    logic signed [TW-1:0] t1;
    logic signed [TW-1:0] t2;
    logic                 use3;
  } sd3_t;

  function automatic logic [DW-1:0] clamp_dir(logic signed [DW-1:0] v);
    logic signed [DW-1:0] o;
    o = v;
    if (v > DLIM) o = DLIM;
    if (v < -DLIM) o = -DLIM;
    return o;
  endfunction

  function automatic logic [PW-1:0] ext_of(logic [PW-1:0] h, logic [PW-1:0] rd);
    logic [PW+1:0] h2;
    logic [PW+1:0] r2;
    h2 = {2'b00, h};
    r2 = {1'b0, rd, 1'b0};
    return (h2 >= r2) ? PW'(h2 - r2) : '0;
  endfunction

  // reference capsule
  logic [2:0][PW-1:0] ref_c;
  logic [2:0][DW-1:0] ref_d;
  logic [PW-1:0]      ref_h;
  logic [PW-1:0]      ref_r;
  logic [2:0][DW-1:0] pd;
  logic [PW-1:0]      pext;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_c <= '0;
      ref_d <= '0;
      ref_h <= '0;
      ref_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        cpi_pkg::REG_CENTER_X: ref_c[0] <= cfg_wdata[PW-1:0];
        cpi_pkg::REG_CENTER_Y: ref_c[1] <= cfg_wdata[PW-1:0];
        cpi_pkg::REG_CENTER_Z: ref_c[2] <= cfg_wdata[PW-1:0];
        cpi_pkg::REG_DIR_X:    ref_d[0] <= cfg_wdata[DW-1:0];
        cpi_pkg::REG_DIR_Y:    ref_d[1] <= cfg_wdata[DW-1:0];
        cpi_pkg::REG_DIR_Z:    ref_d[2] <= cfg_wdata[DW-1:0];
        cpi_pkg::REG_HEIGHT:   ref_h    <= cfg_wdata[PW-1:0];
        cpi_pkg::REG_RADIUS:   ref_r    <= cfg_wdata[PW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pd[i] = clamp_dir($signed(ref_d[i]));
    end
    pext = ext_of(ref_h, ref_r);
  end

  assign busy = 1'b0;

  // stage 1: capture candidate
  logic               v1;
  logic [2:0][PW-1:0] s1_c;
  logic [2:0][DW-1:0] s1_d;
  logic [PW-1:0]      s1_h;
  logic [PW-1:0]      s1_rad;

  always_ff @(posedge clk) begin
    s1_c   <= {cand_center_z, cand_center_y, cand_center_x};
    s1_d   <= {cand_dir_z, cand_dir_y, cand_dir_x};
    s1_h   <= cand_height;
    s1_rad <= cand_radius;
  end

  // stage 2: center offset, clamped direction, extent
  logic               v2;
  logic [2:0][RW-1:0] s2_r;
  logic [2:0][DW-1:0] s2_qd;
  logic [PW-1:0]      s2_qext;
  logic [PW-1:0]      s2_qrad;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s2_r[i]  <= RW'($signed(ref_c[i])) - RW'($signed(s1_c[i]));
      s2_qd[i] <= clamp_dir($signed(s1_d[i]));
    end
    s2_qext <= ext_of(s1_h, s1_rad);
    s2_qrad <= s1_rad;
  end

  // stage 3: per-axis products
  logic                    v3;
  logic [2:0][2*DW-1:0]    s3_pa;
  logic [2:0][2*DW-1:0]    s3_pb;
  logic [2:0][2*DW-1:0]    s3_pc;
  logic [2:0][DW+RW-1:0]   s3_pd;
  logic [2:0][DW+RW-1:0]   s3_pf;
  logic [2:0][RW-1:0]      s3_r;
  logic [2:0][DW-1:0]      s3_qd;
  logic [PW-1:0]           s3_qext;
  logic [PW-1:0]           s3_qrad;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s3_pa[i] <= $signed(pd[i]) * $signed(pd[i]);
      s3_pb[i] <= $signed(pd[i]) * $signed(s2_qd[i]);
      s3_pc[i] <= $signed(s2_qd[i]) * $signed(s2_qd[i]);
      s3_pd[i] <= $signed(pd[i]) * $signed(s2_r[i]);
      s3_pf[i] <= $signed(s2_qd[i]) * $signed(s2_r[i]);
    end
    s3_r    <= s2_r;
    s3_qd   <= s2_qd;
    s3_qext <= s2_qext;
    s3_qrad <= s2_qrad;
  end

  // stage 4: dot products
  logic                 v4;
  logic [AW-1:0]        s4_a;
  logic [AW-1:0]        s4_c;
  logic signed [BW-1:0] s4_b;
  logic signed [FW-1:0] s4_d;
  logic signed [FW-1:0] s4_f;
  logic [2:0][RW-1:0]   s4_r;
  logic [2:0][DW-1:0]   s4_qd;
  logic [PW-1:0]        s4_qext;
  logic [PW-1:0]        s4_qrad;

  always_ff @(posedge clk) begin
    s4_a    <= AW'(s3_pa[0]) + AW'(s3_pa[1]) + AW'(s3_pa[2]);
    s4_b    <= BW'(s3_pb[0]) + BW'(s3_pb[1]) + BW'(s3_pb[2]);
    s4_c    <= AW'(s3_pc[0]) + AW'(s3_pc[1]) + AW'(s3_pc[2]);
    s4_d    <= FW'(s3_pd[0]) + FW'(s3_pd[1]) + FW'(s3_pd[2]);
    s4_f    <= FW'(s3_pf[0]) + FW'(s3_pf[1]) + FW'(s3_pf[2]);
    s4_r    <= s3_r;
    s4_qd   <= s3_qd;
    s4_qext <= s3_qext;
    s4_qrad <= s3_qrad;
  end

  // stage 5: cross products for the line parameter
  logic                    v5;
  logic signed [BW+FW-1:0] s5_bf;
  logic signed [BW+FW-1:0] s5_cd;
  logic [2*AW-1:0]         s5_ac;
  logic signed [2*BW-1:0]  s5_bb;
  sd1_t                    s5_x;

  always_ff @(posedge clk) begin
    s5_bf       <= s4_b * s4_f;
    s5_cd       <= $signed({1'b0, s4_c}) * s4_d;
    s5_ac       <= s4_a * s4_c;
    s5_bb       <= s4_b * s4_b;
    s5_x.b      <= s4_b;
    s5_x.d      <= s4_d;
    s5_x.f      <= s4_f;
    s5_x.a      <= s4_a;
    s5_x.c      <= s4_c;
    s5_x.r      <= s4_r;
    s5_x.qd     <= s4_qd;
    s5_x.qext   <= s4_qext;
    s5_x.qrad   <= s4_qrad;
    s5_x.a_nz   <= s4_a != '0;
    s5_x.c_nz   <= s4_c != '0;
    s5_x.use1   <= 1'b0;
  end

  // first division: reference parameter
  logic signed [NS1-1:0]  num1;
  logic signed [2*BW-1:0] den1;
  logic                   den_pos;
  logic signed [NS1-1:0]  n1;
  logic [NS1-1:0]         n1mag;
  logic [DNW-1:0]         d1den;
  sd1_t                   d1_in;

  always_comb begin
    num1    = NS1'(s5_bf) - NS1'(s5_cd);
    den1    = (2*BW)'($signed({1'b0, s5_ac})) - s5_bb;
    den_pos = !den1[2*BW-1] && (den1 != '0);
    if (!s5_x.c_nz) begin
      n1    = -NS1'(s5_x.d);
      d1den = DNW'(s5_x.a);
    end else begin
      n1    = num1;
      d1den = den1[DNW-1:0];
    end
    n1mag      = n1[NS1-1] ? NS1'(-n1) : NS1'(n1);
    d1_in      = s5_x;
    d1_in.use1 = s5_x.a_nz && (!s5_x.c_nz || den_pos);
  end

  cpi_pkg::div_stat_t   d1_stat;
  logic signed [TW-1:0] d1_quot;
  logic [$bits(sd1_t)-1:0] d1_side;

  cpi_div #(
    .NUM_W (N1W),
    .DEN_W (DNW),
    .Q_W   (TW),
    .SIDE_W($bits(sd1_t))
  ) u_div1 (
    .clk     (clk),
    .rst     (rst),
    .in_valid(v5),
    .num     ({n1mag, {K{1'b0}}}),
    .neg     (n1[NS1-1]),
    .den     (d1den),
    .lim     (pext),
    .side_in (d1_in),
    .stat    (d1_stat),
    .quot    (d1_quot),
    .side_out(d1_side)
  );

  // stage 7: b * t1
  sd1_t                    d1o;
  logic signed [TW-1:0]    t1;
  logic                    v7;
  logic signed [BW+TW-1:0] s7_bt1;
  logic signed [TW-1:0]    s7_t1;
  sd1_t                    s7_x;

  always_comb begin
    d1o = sd1_t'(d1_side);
    t1  = d1o.use1 ? d1_quot : '0;
  end

  always_ff @(posedge clk) begin
    s7_bt1 <= $signed(d1o.b) * t1;
    s7_t1  <= t1;
    s7_x   <= d1o;
  end

  // second division: candidate parameter
  logic signed [N2S-1:0] n2;
  logic [N2S-1:0]        n2mag;
  sd2_t                  d2_in;

  always_comb begin
    n2          = N2S'(s7_bt1) + (N2S'($signed(s7_x.f)) <<< K);
    n2mag       = n2[N2S-1] ? N2S'(-n2) : N2S'(n2);
    d2_in.b     = s7_x.b;
    d2_in.d     = s7_x.d;
    d2_in.a     = s7_x.a;
    d2_in.r     = s7_x.r;
    d2_in.qd    = s7_x.qd;
    d2_in.qrad  = s7_x.qrad;
    d2_in.t1    = s7_t1;
    d2_in.a_nz  = s7_x.a_nz;
    d2_in.c_nz  = s7_x.c_nz;
  end

  cpi_pkg::div_stat_t   d2_stat;
  logic signed [TW-1:0] d2_quot;
  logic [$bits(sd2_t)-1:0] d2_side;

  cpi_div #(
    .NUM_W (N2S),
    .DEN_W (AW),
    .Q_W   (TW),
    .SIDE_W($bits(sd2_t))
  ) u_div2 (
    .clk     (clk),
    .rst     (rst),
    .in_valid(v7),
    .num     (n2mag),
    .neg     (n2[N2S-1]),
    .den     (s7_x.c),
    .lim     (s7_x.qext),
    .side_in (d2_in),
    .stat    (d2_stat),
    .quot    (d2_quot),
    .side_out(d2_side)
  );

  // stage 9: b * t2
  sd2_t                    d2o;
  logic signed [TW-1:0]    t2;
  logic                    v9;
  logic signed [BW+TW-1:0] s9_bt2;
  logic signed [TW-1:0]    s9_t2;
  logic                    s9_use3;
  sd2_t                    s9_x;

  always_comb begin
    d2o = sd2_t'(d2_side);
    t2  = d2o.c_nz ? d2_quot : '0;
  end

  always_ff @(posedge clk) begin
    s9_bt2  <= $signed(d2o.b) * t2;
    s9_t2   <= t2;
    // candidate parameter clamped: recompute the reference parameter from it
    s9_use3 <= d2o.a_nz && d2o.c_nz && d2_stat.sat;
    s9_x    <= d2o;
  end

  // third division: reference parameter from clamped candidate parameter
  logic signed [N2S-1:0] n3;
  logic [N2S-1:0]        n3mag;
  sd3_t                  d3_in;

  always_comb begin
    n3          = N2S'(s9_bt2) - (N2S'($signed(s9_x.d)) <<< K);
    n3mag       = n3[N2S-1] ? N2S'(-n3) : N2S'(n3);
    d3_in.r     = s9_x.r;
    d3_in.qd    = s9_x.qd;
    d3_in.qrad  = s9_x.qrad;
    d3_in.t1    = s9_x.t1;
    d3_in.t2    = s9_t2;
    d3_in.use3  = s9_use3;
  end

  cpi_pkg::div_stat_t   d3_stat;
  logic signed [TW-1:0] d3_quot;
  logic [$bits(sd3_t)-1:0] d3_side;

  cpi_div #(
    .NUM_W (N2S),
    .DEN_W (AW),
    .Q_W   (TW),
    .SIDE_W($bits(sd3_t))
  ) u_div3 (
    .clk     (clk),
    .rst     (rst),
    .in_valid(v9),
    .num     (n3mag),
    .neg     (n3[N2S-1]),
    .den     (s9_x.a),
    .lim     (pext),
    .side_in (d3_in),
    .stat    (d3_stat),
    .quot    (d3_quot),
    .side_out(d3_side)
  );

  // stage 11: closest-point products
  sd3_t                  d3o;
  logic signed [TW-1:0]  t1f;
  logic                  v11;
  logic [2:0][TW+DW-1:0] s11_p1;
  logic [2:0][TW+DW-1:0] s11_p2;
  logic [2:0][RW-1:0]    s11_r;
  logic [PW-1:0]         s11_qrad;

  always_comb begin
    d3o = sd3_t'(d3_side);
    t1f = d3o.use3 ? d3_quot : d3o.t1;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s11_p1[i] <= t1f * $signed(pd[i]);
      s11_p2[i] <= $signed(d3o.t2) * $signed(d3o.qd[i]);
    end
    s11_r    <= d3o.r;
    s11_qrad <= d3o.qrad;
  end

  // stage 12: difference vector, rounded to 2^-13 of a position unit, halves up
  logic signed [WW-1:0] w  [3];
  logic signed [WW-1:0] wy [3];
  logic                 v12;
  logic [2:0][SW-1:0]   s12_s;
  logic [PW:0]          s12_rs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w[i]  = (WW'($signed(s11_r[i])) <<< K) + WW'($signed(s11_p1[i]))
              - WW'($signed(s11_p2[i]));
      wy[i] = w[i] + WW'(2);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s12_s[i] <= SW'(wy[i] >>> 2);
    end
    s12_rs <= (PW+1)'(s11_qrad) + (PW+1)'(ref_r);
  end

  // stage 13: squares
  logic                 v13;
  logic [2:0][2*SW-1:0] s13_sq;
  logic [2*PW+1:0]      s13_rs2;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s13_sq[i] <= $signed(s12_s[i]) * $signed(s12_s[i]);
    end
    s13_rs2 <= s12_rs * s12_rs;
  end

  // final compare
  logic [DSW-1:0] dsq;
  logic [THW-1:0] thr2;

  always_comb begin
    dsq  = DSW'(s13_sq[0]) + DSW'(s13_sq[1]) + DSW'(s13_sq[2]);
    thr2 = THW'(s13_rs2) << (2 * (DIR_FRAC_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      v7   <= 1'b0;
      v9   <= 1'b0;
      v11  <= 1'b0;
      v12  <= 1'b0;
      v13  <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      v7   <= d1_stat.valid;
      v9   <= d2_stat.valid;
      v11  <= d3_stat.valid;
      v12  <= v11;
      v13  <= v12;
      done <= v13;
    end
  end

  always_ff @(posedge clk) begin
    hit <= CMPW'(dsq) < CMPW'(thr2);
  end

endmodule

/* rtl/cpi_div.sv */
module cpi_div #(
  parameter int NUM_W  = 48,
  parameter int DEN_W  = 30,
  parameter int Q_W    = 17,
  parameter int SIDE_W = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [NUM_W-1:0]         num,
  input  logic                     neg,
  input  logic [DEN_W-1:0]         den,
  input  logic [Q_W-2:0]           lim,
  input  logic [SIDE_W-1:0]        side_in,
  output cpi_pkg::div_stat_t       stat,
  output logic signed [Q_W-1:0]    quot,
  output logic [SIDE_W-1:0]        side_out
);

  localparam int XW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [XW-1:0]     rem  [Q_W+1];
  logic [DEN_W-1:0]  dv   [Q_W+1];
  logic [Q_W-1:0]    qacc [Q_W+1];
  logic              ovf  [Q_W+1];
  logic              sg   [Q_W+1];
  logic              vld  [Q_W+1];
  logic [Q_W-2:0]    lm   [Q_W+1];
  logic [SIDE_W-1:0] sd   [Q_W+1];

  logic [XW-1:0] dsh [Q_W];
  logic          ge  [Q_W];

  logic [Q_W-1:0] qz;
  logic [Q_W-1:0] limx;
  logic [Q_W-1:0] mag;
  logic           over;
  logic           out_v;
  logic           out_sat;

  // one quotient bit per stage, most significant first
  always_comb begin
    for (int k = 0; k < Q_W; k++) begin
      dsh[k] = XW'(dv[k]) << (Q_W - 1 - k);
      ge[k]  = rem[k] >= dsh[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= Q_W; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      vld[0] <= in_valid;
      for (int k = 0; k < Q_W; k++) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    rem[0]  <= XW'(num);
    dv[0]   <= den;
    qacc[0] <= '0;
    ovf[0]  <= XW'(num) >= (XW'(den) << Q_W);
    sg[0]   <= neg;
    lm[0]   <= lim;
    sd[0]   <= side_in;
    for (int k = 0; k < Q_W; k++) begin
      rem[k+1]  <= ge[k] ? rem[k] - dsh[k] : rem[k];
      qacc[k+1] <= qacc[k] | (Q_W'(ge[k]) << (Q_W - 1 - k));
      dv[k+1]   <= dv[k];
      ovf[k+1]  <= ovf[k];
      sg[k+1]   <= sg[k];
      lm[k+1]   <= lm[k];
      sd[k+1]   <= sd[k];
    end
  end

  // clamp to the limit; flag when the exact quotient lies beyond it
  always_comb begin
    qz   = qacc[Q_W];
    limx = {1'b0, lm[Q_W]};
    over = ovf[Q_W] || (qz > limx) || ((qz == limx) && (rem[Q_W] != '0));
    mag  = over ? limx : qz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else begin
      out_v <= vld[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    quot     <= sg[Q_W] ? -$signed(mag) : $signed(mag);
    out_sat  <= over;
    side_out <= sd[Q_W];
  end

  assign stat = '{valid: out_v, sat: out_sat};

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0][15:0] capsule_t;  // index order matches the register map

  typedef struct {
    longint c[3];
    longint d[3];
    longint ext;
    longint rad;
  } axis_seg_t;

  class hit_scoreboard;
    bit pending_hits[$];
    function void note_item(bit h);
      pending_hits.push_back(h);
    endfunction
    // 0: ok, 1: no item waiting, 2: wrong value
    function int check_hit(bit h, output bit want);
      want = 0;
      if (pending_hits.size() == 0) return 1;
      want = pending_hits.pop_front();
      return (want == h) ? 0 : 2;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic cfg_we;
  logic [cpi_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [15:0] cfg_wdata;
  logic signed [15:0] cand_center_x, cand_center_y, cand_center_z;
  logic signed [15:0] cand_dir_x, cand_dir_y, cand_dir_z;
  logic [15:0] cand_height, cand_radius;
  logic done;
  logic hit;

  capsule_t ref_caps;
  hit_scoreboard sb;
  int fail_count;

  capsule_pair_intersect_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .cand_center_x(cand_center_x), .cand_center_y(cand_center_y),
    .cand_center_z(cand_center_z), .cand_dir_x(cand_dir_x),
    .cand_dir_y(cand_dir_y), .cand_dir_z(cand_dir_z),
    .cand_height(cand_height), .cand_radius(cand_radius),
    .done(done), .hit(hit)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic axis_seg_t to_segment(capsule_t k);
    axis_seg_t s;
    for (int i = 0; i < 3; i++) begin
      s.c[i] = longint'($signed(k[i]));
      s.d[i] = longint'($signed(k[3+i]));
      if (s.d[i] > 16384) s.d[i] = 16384;
      if (s.d[i] < -16384) s.d[i] = -16384;
    end
    s.rad = longint'(k[7]);
    s.ext = longint'(k[6]) - 2 * s.rad;
    if (s.ext < 0) s.ext = 0;
    return s;
  endfunction

  function automatic longint dot3(longint p[3], longint q[3]);
    return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
  endfunction

  // truncated num*2^sh/den clamped to +-lim; over set when exact value lies outside
  function automatic longint clamped_quot(longint num, longint den, int sh, longint lim,
                                          output bit over);
    bit neg;
    longint unsigned mag, ud, ul, q, rem;
    neg = num < 0;
    mag = neg ? -num : num;
    ud = den;
    ul = lim;
    q = mag / ud;
    rem = mag % ud;
    over = q > ul;
    for (int i = 0; i < sh && !over; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= ud) begin
        rem = rem - ud;
        q = q | 1;
      end
      if (q > ul) over = 1;
    end
    if (!over && q == ul && rem != 0) over = 1;
    if (over) q = ul;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint round_q21(longint x);
    longint y;
    y = x + 2;
    if (y >= 0) return y >>> 2;
    return -(((-y) + 3) >>> 2);
  endfunction

  function automatic bit predict_overlap(capsule_t cand);
    axis_seg_t p, q;
    longint r[3];
    longint a, b, c, d, f, t1, t2, sq_sum, thr, den, w, s;
    longint k;
    bit over;
    k = 64'sd1 << 15;
    p = to_segment(ref_caps);
    q = to_segment(cand);
    for (int i = 0; i < 3; i++) r[i] = p.c[i] - q.c[i];
    a = dot3(p.d, p.d);
    b = dot3(p.d, q.d);
    c = dot3(q.d, q.d);
    d = dot3(p.d, r);
    f = dot3(q.d, r);
    t1 = 0;
    t2 = 0;
    sq_sum = 0;
    if (a == 0 && c == 0) begin
      t1 = 0;
    end else if (a == 0) begin
      t2 = clamped_quot(f * k, c, 0, q.ext, over);
    end else if (c == 0) begin
      t1 = clamped_quot(-(d * k), a, 0, p.ext, over);
    end else begin
      den = a * c - b * b;
      if (den > 0) t1 = clamped_quot(b * f - c * d, den, 15, p.ext, over);
      t2 = clamped_quot(b * t1 + f * k, c, 0, q.ext, over);
      // second parameter clipped: recompute the first from it
      if (over) t1 = clamped_quot(b * t2 - d * k, a, 0, p.ext, over);
    end
    for (int i = 0; i < 3; i++) begin
      w = r[i] * k + t1 * p.d[i] - t2 * q.d[i];
      s = round_q21(w);
      sq_sum += s * s;
    end
    thr = (p.rad + q.rad) * 8192;
    return sq_sum < thr * thr;
  endfunction

  always @(posedge clk) begin
    bit want;
    int st;
    if (!rst && done) begin
      st = sb.check_hit(hit, want);
      if (st == 1) report_mismatch("result with no item pending");
      else if (st == 2) report_mismatch($sformatf("hit %0b, expected %0b", hit, want));
    end
  end

  // write all eight reference registers, one per cycle
  task automatic load_reference(capsule_t v);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= i[cpi_pkg::CFG_IDX_W-1:0];
      cfg_wdata <= v[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    ref_caps = v;
    @(posedge clk);
  endtask

  task automatic send_item(capsule_t v, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cand_center_x <= v[0];
    cand_center_y <= v[1];
    cand_center_z <= v[2];
    cand_dir_x <= v[3];
    cand_dir_y <= v[4];
    cand_dir_z <= v[5];
    cand_height <= v[6];
    cand_radius <= v[7];
    do @(posedge clk); while (busy);
    sb.note_item(predict_overlap(v));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(5))
      0: return 16'(16384);
      1: return -16'sd16384;
      2: return 16'(0);
      3: return 16'($urandom);  // full range, clamped by the block
      default: return 16'($urandom_range(32768) - 16384);
    endcase
  endfunction

  function automatic capsule_t rand_capsule(capsule_t around);
    capsule_t v;
    if ($urandom_range(9) < 2) begin
      for (int i = 0; i < 8; i++) v[i] = 16'($urandom);
      return v;
    end
    for (int i = 0; i < 3; i++)
      v[i] = around[i] + 16'($urandom_range(4096) - 2048);
    for (int i = 3; i < 6; i++) v[i] = rand_dir();
    v[7] = 16'($urandom_range(1200));
    v[6] = ($urandom_range(3) == 0) ? 16'($urandom_range(1000)) : 16'($urandom_range(6000));
    return v;
  endfunction

  function automatic capsule_t mk(int cx, int cy, int cz, int dx, int dy, int dz,
                                  int h, int r);
    capsule_t v;
    v[0] = 16'(cx); v[1] = 16'(cy); v[2] = 16'(cz);
    v[3] = 16'(dx); v[4] = 16'(dy); v[5] = 16'(dz);
    v[6] = 16'(h); v[7] = 16'(r);
    return v;
  endfunction

  initial begin
    capsule_t rc;
    int idle_pct;
    sb = new();
    fail_count = 0;
    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    cand_center_x = '0; cand_center_y = '0; cand_center_z = '0;
    cand_dir_x = '0; cand_dir_y = '0; cand_dir_z = '0;
    cand_height = '0; cand_radius = '0;
    ref_caps = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset reference: a point at the origin, so everything is sphere tests
    send_item(mk(0, 0, 0, 0, 0, 0, 0, 0), 0);          // zero radii, touching
    send_item(mk(100, 0, 0, 0, 0, 0, 0, 101), 0);
    send_item(mk(100, 0, 0, 0, 0, 0, 0, 100), 0);       // exactly touching
    drain();

    load_reference(mk(0, 0, 0, 16384, 0, 0, 2048, 256));
    send_item(mk(0, 512, 0, 16384, 0, 0, 2048, 256), 0);  // parallel
    send_item(mk(0, 512, 0, -16384, 0, 0, 2048, 255), 0); // antiparallel, just apart
    send_item(mk(3000, 0, 0, 16384, 0, 0, 4000, 100), 0); // collinear, end to end
    send_item(mk(0, 0, 300, 0, 16384, 0, 3000, 50), 0);  // crossing
    send_item(mk(0, 0, 700, 0, 0, 16384, 100, 200), 0);  // height below 2r
    send_item(mk(32767, 32767, 32767, 16384, 16384, 16384, 65535, 65535), 0);
    send_item(mk(-32768, -32768, -32768, -16384, -16384, -16384, 65535, 0), 0);
    send_item(mk(0, 0, 0, 32767, -32768, 16385, 5000, 10), 0);   // clamp dirs
    send_item(mk(1000, 200, 0, 8000, 8000, 0, 4000, 30), 0);      // non-unit dir
    send_item(mk(0, 0, 0, 0, 0, 0, 0, 0), 0);
    send_item(mk(5000, 0, 0, 0, 0, 0, 0, 65535), 0);             // zero dir, big sphere
    send_item(mk(-3000, 100, -20, 16384, 0, 0, 65535, 1), 0);
    drain();

    load_reference(mk(-32768, -32768, -32768, -16384, -16384, -16384, 0, 0));
    send_item(mk(-32768, -32768, -32768, 0, 0, 0, 0, 1), 0);
    send_item(mk(32767, 32767, 32767, 16384, -16384, 16384, 65535, 65535), 0);
    send_item(mk(-32000, -32768, -32768, 16384, 0, 0, 1000, 0), 0);
    drain();

    load_reference(mk(32767, 32767, 32767, 32767, 32768, 16384, 65535, 65535));
    for (int n = 0; n < 50; n++) send_item(rand_capsule(ref_caps), 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < 8; i++) rc[i] = 16'($urandom);
      rc[6] = 16'($urandom_range(8000));
      rc[7] = 16'($urandom_range(1500));
      if (ph % 3 != 0) for (int i = 3; i < 6; i++) rc[i] = rand_dir();
      load_reference(rc);
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 70;
        2: idle_pct = 14;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < 130; n++) begin
        // alternate with an unstalled burst inside stalled phases
        send_item(rand_capsule(ref_caps), (n % 40 < 10) ? 0 : idle_pct);
      end
      drain();
    end

    if (sb.pending_hits.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", sb.pending_hits.size()));
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
